[sv/lsf_pkg.sv]
// ---------------------------------------------------------------------------
// lsf_pkg: shared types and constants
// Status codes, request kinds and the divider handshake structs.
// ---------------------------------------------------------------------------
package lsf_pkg;

	localparam int VAL_W   = 16;
	localparam int DIV_CW  = 4;
	localparam int MAX_RES = 6;
	localparam int K_W     = 3;
	localparam int EXP_W   = 5;
	localparam int DC_W    = 8;
	localparam int PC_W    = 14;

	localparam logic [1:0] KIND_BUILD = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_PRIME = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_INDEX   = 2'd2;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] dividend;
		logic [VAL_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quotient;
	} div_rsp_t;

endpackage

[sv/lsf_div.sv]
// ---------------------------------------------------------------------------
// lsf_div: restoring divider
// One quotient bit per cycle; done pulses once all VAL_W quotient bits are shifted in.
// ---------------------------------------------------------------------------
module lsf_div
	import lsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              run_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [VAL_W-1:0]  dvs_q;
	logic [VAL_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(VAL_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= fits ? VAL_W'(trial - {1'b0, dvs_q}) : trial[VAL_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[sv/linear_sieve_factorizer_core.sv]
// ---------------------------------------------------------------------------
// linear_sieve_factorizer_core: smallest-prime-factor sieve and factorizer
// Least-factor table and prime list in synchronous RAMs, one FSM on top.
// ---------------------------------------------------------------------------
// Usage:
//   Command in: kind/value, transferred when start is high and busy is low.
//   Config: cfg_we/cfg_wdata sets the sieve limit for the next build.
//   Results: one cycle each on the result ports, marked by valid; the
//   receiver cannot stall, last marks the final result of a command.
// Steps:
//   Build: clears table entries 2 to L (L = limit), then for each
//   candidate reads its entry and walks the prime list, with a prime read,
//   a multiply and a table write per step. Result follows at the end.
//   Query: range errors and values 0/1 answer from the idle state.
//   Otherwise the first table read, then per prime division the divider
//   run to its done pulse and the table read of the quotient.
//   Prime read: one prime-list read, then the result.
//   One command at a time; busy is high while a command is at work.
// Reset: counts, built limit and sieve limit clear; the table needs no
//   clearing pass since no query reads it before a build.
// ---------------------------------------------------------------------------
module linear_sieve_factorizer_core
	import lsf_pkg::*;
#(
	parameter int MAX_LIMIT   = 65535,
	parameter int PRIME_SLOTS = 8192
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       kind,
	input  logic [15:0]      value,
	output logic             valid,
	output logic [1:0]       status,
	output logic [15:0]      prime,
	output logic [4:0]       exponent,
	output logic             is_prime_flag,
	output logic [7:0]       divisor_count,
	output logic [13:0]      prime_count,
	output logic             last
);

	localparam int LIM_MAX   = (MAX_LIMIT < 65535) ? MAX_LIMIT : 65535;
	localparam int TAB_DEPTH = LIM_MAX + 1;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int PL_AW     = $clog2(PRIME_SLOTS);
	localparam int CNT_W     = $clog2(PRIME_SLOTS + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_B_RDI  = 4'd2;
	localparam logic [3:0] S_B_GETI = 4'd3;
	localparam logic [3:0] S_B_RDP  = 4'd4;
	localparam logic [3:0] S_B_GETP = 4'd5;
	localparam logic [3:0] S_B_MUL  = 4'd6;
	localparam logic [3:0] S_B_WR   = 4'd7;
	localparam logic [3:0] S_B_DONE = 4'd8;
	localparam logic [3:0] S_Q_FST  = 4'd9;
	localparam logic [3:0] S_Q_DIV  = 4'd10;
	localparam logic [3:0] S_Q_CHK  = 4'd11;
	localparam logic [3:0] S_P_RD   = 4'd12;

	// memories
	logic [TAB_AW-1:0] lft_mem [TAB_DEPTH];
	logic [TAB_AW-1:0] pl_mem  [PRIME_SLOTS];
	logic              lft_re, lft_we, pl_re, pl_we;
	logic [TAB_AW-1:0] lft_ra, lft_wa, lft_wd, lft_rd, pl_wd, pl_rd;
	logic [PL_AW-1:0]  pl_ra, pl_wa;

	always_ff @(posedge clk) begin
		if (lft_we) lft_mem[lft_wa] <= lft_wd;
		if (lft_re) lft_rd <= lft_mem[lft_ra];
	end

	always_ff @(posedge clk) begin
		if (pl_we) pl_mem[pl_wa] <= pl_wd;
		if (pl_re) pl_rd <= pl_mem[pl_ra];
	end

	// state
	logic [3:0]          state_q, state_d;
	logic [15:0]         cfg_lim_q;
	logic [TAB_AW-1:0]   lim_q, lim_d, built_q, built_d;
	logic [CNT_W-1:0]    found_q, found_d, j_q, j_d;
	logic [TAB_AW-1:0]   i_q, i_d, clr_q, clr_d, spf_q, spf_d, p_q, p_d;
	logic [2*TAB_AW-1:0] m_q, m_d;
	logic [TAB_AW-1:0]   a_q, a_d, cur_q, cur_d;
	logic [EXP_W-1:0]    e_q, e_d, mul_e;
	logic [K_W-1:0]      k_q, k_d;
	logic [DC_W-1:0]     divs_q, divs_d, dmul;
	logic                isp_q, isp_d;

	logic                emit;
	logic [1:0]          e_status;
	logic [TAB_AW-1:0]   e_prime;
	logic [EXP_W-1:0]    e_exp;
	logic                e_isp;
	logic [DC_W-1:0]     e_divs;
	logic                e_last;

	div_req_t            dreq;
	div_rsp_t            drsp;

	logic [31:0]         vx;
	logic [TAB_AW-1:0]   lim_cfg;
	logic                q_last;

	lsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign vx      = 32'(value);
	assign lim_cfg = (32'(cfg_lim_q) > LIM_MAX) ? TAB_AW'(LIM_MAX) : TAB_AW'(cfg_lim_q);
	assign mul_e   = (state_q == S_Q_DIV) ? EXP_W'(e_q + 1'b1) : e_q;
	assign dmul    = DC_W'(divs_q * (6'(mul_e) + 6'd1));
	assign busy    = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		lim_d   = lim_q;
		built_d = built_q;
		found_d = found_q;
		j_d     = j_q;
		i_d     = i_q;
		clr_d   = clr_q;
		spf_d   = spf_q;
		p_d     = p_q;
		m_d     = m_q;
		a_d     = a_q;
		cur_d   = cur_q;
		e_d     = e_q;
		k_d     = k_q;
		divs_d  = divs_q;
		isp_d   = isp_q;
		lft_re  = 1'b0;
		lft_ra  = '0;
		lft_we  = 1'b0;
		lft_wa  = '0;
		lft_wd  = '0;
		pl_re   = 1'b0;
		pl_ra   = '0;
		pl_we   = 1'b0;
		pl_wa   = '0;
		pl_wd   = '0;
		emit     = 1'b0;
		e_status = ST_OK;
		e_prime  = '0;
		e_exp    = '0;
		e_isp    = 1'b0;
		e_divs   = '0;
		e_last   = 1'b1;
		dreq.start    = 1'b0;
		dreq.dividend = VAL_W'(a_q);
		dreq.divisor  = VAL_W'(cur_q);
		q_last        = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_BUILD: begin
							lim_d   = lim_cfg;
							built_d = lim_cfg;
							found_d = '0;
							clr_d   = TAB_AW'(2);
							i_d     = TAB_AW'(2);
							state_d = (32'(lim_cfg) < 2) ? S_B_DONE : S_CLR;
						end
						KIND_QUERY: begin
							if (vx > 32'(built_q)) begin
								emit     = 1'b1;
								e_status = ST_RANGE;
							end else if (vx < 2) begin
								emit   = 1'b1;
								e_divs = DC_W'(1);
							end else begin
								lft_re  = 1'b1;
								lft_ra  = vx[TAB_AW-1:0];
								a_d     = vx[TAB_AW-1:0];
								k_d     = '0;
								divs_d  = DC_W'(1);
								state_d = S_Q_FST;
							end
						end
						KIND_PRIME: begin
							if (vx >= 32'(found_q)) begin
								emit     = 1'b1;
								e_status = ST_INDEX;
							end else begin
								pl_re   = 1'b1;
								pl_ra   = vx[PL_AW-1:0];
								state_d = S_P_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_CLR: begin
				lft_we = 1'b1;
				lft_wa = clr_q;
				if (clr_q == lim_q) state_d = S_B_RDI;
				else clr_d = clr_q + 1'b1;
			end
			S_B_RDI: begin
				lft_re  = 1'b1;
				lft_ra  = i_q;
				state_d = S_B_GETI;
			end
			S_B_GETI: begin
				j_d     = '0;
				state_d = S_B_RDP;
				if (lft_rd == '0) begin
					if (32'(found_q) >= PRIME_SLOTS) begin
						built_d = i_q - 1'b1;
						state_d = S_B_DONE;
					end else begin
						lft_we  = 1'b1;
						lft_wa  = i_q;
						lft_wd  = i_q;
						pl_we   = 1'b1;
						pl_wa   = found_q[PL_AW-1:0];
						pl_wd   = i_q;
						found_d = found_q + 1'b1;
						spf_d   = i_q;
					end
				end else begin
					spf_d = lft_rd;
				end
			end
			S_B_RDP: begin
				if (j_q >= found_q) begin
					if (i_q == lim_q) state_d = S_B_DONE;
					else begin
						i_d     = i_q + 1'b1;
						state_d = S_B_RDI;
					end
				end else begin
					pl_re   = 1'b1;
					pl_ra   = j_q[PL_AW-1:0];
					state_d = S_B_GETP;
				end
			end
			S_B_GETP: begin
				p_d     = pl_rd;
				state_d = S_B_MUL;
			end
			S_B_MUL: begin
				m_d     = i_q * p_q;
				state_d = S_B_WR;
			end
			S_B_WR: begin
				if (p_q > spf_q || m_q > (2*TAB_AW)'(lim_q)) begin
					if (i_q == lim_q) state_d = S_B_DONE;
					else begin
						i_d     = i_q + 1'b1;
						state_d = S_B_RDI;
					end
				end else begin
					lft_we  = 1'b1;
					lft_wa  = m_q[TAB_AW-1:0];
					lft_wd  = p_q;
					j_d     = j_q + 1'b1;
					state_d = S_B_RDP;
				end
			end
			S_B_DONE: begin
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_Q_FST: begin
				isp_d = lft_rd == a_q;
				if (32'(lft_rd) < 2) begin
					emit    = 1'b1;
					e_divs  = DC_W'(1);
					state_d = S_IDLE;
				end else begin
					cur_d         = lft_rd;
					e_d           = '0;
					dreq.start    = 1'b1;
					dreq.divisor  = VAL_W'(lft_rd);
					state_d       = S_Q_DIV;
				end
			end
			S_Q_DIV: begin
				if (drsp.done) begin
					a_d = drsp.quotient[TAB_AW-1:0];
					e_d = e_q + 1'b1;
					if (drsp.quotient <= VAL_W'(1)) begin
						emit    = 1'b1;
						e_prime = cur_q;
						e_exp   = e_q + 1'b1;
						e_isp   = isp_q;
						e_divs  = dmul;
						state_d = S_IDLE;
					end else begin
						lft_re  = 1'b1;
						lft_ra  = drsp.quotient[TAB_AW-1:0];
						state_d = S_Q_CHK;
					end
				end
			end
			S_Q_CHK: begin
				if (lft_rd == cur_q) begin
					dreq.start = 1'b1;
					state_d    = S_Q_DIV;
				end else begin
					q_last  = (k_q == K_W'(MAX_RES - 1)) || (32'(lft_rd) < 2);
					emit    = 1'b1;
					e_prime = cur_q;
					e_exp   = e_q;
					e_last  = q_last;
					if (q_last) begin
						e_isp   = isp_q;
						e_divs  = dmul;
						state_d = S_IDLE;
					end else begin
						cur_d        = lft_rd;
						e_d          = '0;
						k_d          = k_q + 1'b1;
						divs_d       = dmul;
						dreq.start   = 1'b1;
						dreq.divisor = VAL_W'(lft_rd);
						state_d      = S_Q_DIV;
					end
				end
			end
			S_P_RD: begin
				emit    = 1'b1;
				e_prime = pl_rd;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cfg_lim_q <= '0;
			built_q   <= '0;
			found_q   <= '0;
			valid     <= 1'b0;
		end else begin
			state_q <= state_d;
			built_q <= built_d;
			found_q <= found_d;
			valid   <= emit;
			if (cfg_we) cfg_lim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		lim_q  <= lim_d;
		j_q    <= j_d;
		i_q    <= i_d;
		clr_q  <= clr_d;
		spf_q  <= spf_d;
		p_q    <= p_d;
		m_q    <= m_d;
		a_q    <= a_d;
		cur_q  <= cur_d;
		e_q    <= e_d;
		k_q    <= k_d;
		divs_q <= divs_d;
		isp_q  <= isp_d;
		if (emit) begin
			status        <= e_status;
			prime         <= 16'(e_prime);
			exponent      <= e_exp;
			is_prime_flag <= e_isp;
			divisor_count <= e_divs;
			prime_count   <= PC_W'(found_d);
			last          <= e_last;
		end
	end

endmodule

[sv/lsf_chk.sv]
// ---------------------------------------------------------------------------
// lsf_chk: port-level checks for the sieve factorizer
// Watches command and result ports over time; bound to the top level.
// ---------------------------------------------------------------------------
module lsf_chk
	import lsf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  kind,
	input logic        valid,
	input logic [1:0]  status,
	input logic        is_prime_flag,
	input logic [7:0]  divisor_count,
	input logic        last
);

	// a build transfer is always followed by busy
	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind == KIND_BUILD |=> busy)
		else $error("build transfer did not raise busy");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_OK |-> last)
		else $error("error result not final");

	// more results pending: command must still be at work
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("non-final result while idle");

	a_mid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> !is_prime_flag && divisor_count == '0)
		else $error("summary fields on non-final result");

endmodule

bind linear_sieve_factorizer_core lsf_chk u_lsf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.valid         (valid),
	.status        (status),
	.is_prime_flag (is_prime_flag),
	.divisor_count (divisor_count),
	.last          (last)
);

[tb/sv/tb_linear_sieve_factorizer_core.sv]
// ---------------------------------------------------------------------------
// tb_linear_sieve_factorizer_core: self-checking bench for the sieve core
// Drives build, factor-query and prime-read commands with random gaps,
// predicts every result with a local sieve and checks each result in order.
// ---------------------------------------------------------------------------
module tb_linear_sieve_factorizer_core;
	import lsf_pkg::*;

	localparam int SIEVE_MAX = 65535;
	localparam int LIST_SLOTS = 8192;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] prime;
		logic [4:0]  exponent;
		logic        is_prime_flag;
		logic [7:0]  divisor_count;
		logic [13:0] prime_count;
		logic        last;
	} factor_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        start;
	logic        busy;
	logic [1:0]  kind;
	logic [15:0] value;
	logic        valid;
	logic [1:0]  status;
	logic [15:0] prime;
	logic [4:0]  exponent;
	logic        is_prime_flag;
	logic [7:0]  divisor_count;
	logic [13:0] prime_count;
	logic        last;

	// local copy of the sieve state
	int spf_table[SIEVE_MAX+1];
	int prime_tab[LIST_SLOTS];
	int n_primes;
	int covered_limit;
	int limit_reg;

	factor_res_t expected_results[$];
	int          mismatches;
	bit          steady_drive;

	linear_sieve_factorizer_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .kind(kind), .value(value), .valid(valid),
		.status(status), .prime(prime), .exponent(exponent),
		.is_prime_flag(is_prime_flag), .divisor_count(divisor_count),
		.prime_count(prime_count), .last(last)
	);

	always #10 clk = ~clk;

	function automatic void run_sieve();
		int lim;
		lim = limit_reg > SIEVE_MAX ? SIEVE_MAX : limit_reg;
		foreach (spf_table[n]) spf_table[n] = 0;
		n_primes = 0;
		covered_limit = lim;
		for (int i = 2; i <= lim; i++) begin
			if (spf_table[i] == 0) begin
				if (n_primes >= LIST_SLOTS) begin
					covered_limit = i - 1;
					return;
				end
				spf_table[i] = i;
				prime_tab[n_primes++] = i;
			end
			for (int j = 0; j < n_primes; j++) begin
				longint m;
				m = longint'(i) * prime_tab[j];
				if (prime_tab[j] > spf_table[i] || m > lim) break;
				spf_table[m] = prime_tab[j];
			end
		end
	endfunction

	function automatic factor_res_t mk_res(logic [1:0] st, int pr, int ex, int ip,
			int dc, logic lst);
		factor_res_t r;
		r.status = st;
		r.prime = pr[15:0];
		r.exponent = ex[4:0];
		r.is_prime_flag = ip[0];
		r.divisor_count = dc[7:0];
		r.prime_count = n_primes[13:0];
		r.last = lst;
		return r;
	endfunction

	function automatic void predict_command(logic [1:0] k, int v);
		factor_res_t fr[$];
		int a, divs, e, p;
		if (k == KIND_BUILD) begin
			run_sieve();
			expected_results.push_back(mk_res(ST_OK, 0, 0, 0, 0, 1'b1));
		end else if (k == KIND_PRIME) begin
			if (v >= n_primes)
				expected_results.push_back(mk_res(ST_INDEX, 0, 0, 0, 0, 1'b1));
			else
				expected_results.push_back(mk_res(ST_OK, prime_tab[v], 0, 0, 0, 1'b1));
		end else if (k == KIND_QUERY) begin
			if (v > covered_limit) begin
				expected_results.push_back(mk_res(ST_RANGE, 0, 0, 0, 0, 1'b1));
				return;
			end
			a = v;
			divs = 1;
			while (a > 1 && fr.size() < MAX_RES) begin
				p = spf_table[a];
				if (p < 2) break;
				e = 0;
				while (a > 1 && spf_table[a] == p) begin
					a = a / p;
					e++;
				end
				divs *= e + 1;
				fr.push_back(mk_res(ST_OK, p, e, 0, 0, 1'b0));
			end
			if (fr.size() == 0) begin
				expected_results.push_back(mk_res(ST_OK, 0, 0, 0, 1, 1'b1));
				return;
			end
			fr[fr.size()-1].is_prime_flag = (spf_table[v] == v);
			fr[fr.size()-1].divisor_count = divs[7:0];
			fr[fr.size()-1].last = 1'b1;
			foreach (fr[i]) expected_results.push_back(fr[i]);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		factor_res_t got, exp_r;
		if (arst_n && valid) begin
			got = '{status, prime, exponent, is_prime_flag, divisor_count,
				prime_count, last};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %p", got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_r, got);
				end
			end
		end
	end

	// start stays high after a transfer until the next command or an idle cycle
	task automatic send_cmd(logic [1:0] k, int v);
		if (!steady_drive)
			while ($urandom_range(99) < 35) begin
				@(negedge clk);
				start = 1'b0;
			end
		@(negedge clk);
		start = 1'b1;
		kind = k;
		value = v[15:0];
		do @(posedge clk); while (busy);
		predict_command(k, v);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_limit(int lim);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = lim[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
		limit_reg = lim;
	endtask

	task automatic test_before_build();
		send_cmd(KIND_QUERY, 0);
		send_cmd(KIND_QUERY, 1);
		send_cmd(KIND_QUERY, 5);
		send_cmd(KIND_PRIME, 0);
		send_cmd(KIND_UNUSED, 16'hFFFF);   // unused kind: no result
	endtask

	task automatic test_small_limits();
		write_limit(0);
		send_cmd(KIND_BUILD, 0);
		send_cmd(KIND_QUERY, 0);
		send_cmd(KIND_QUERY, 1);
		write_limit(1);
		send_cmd(KIND_BUILD, 0);
		send_cmd(KIND_QUERY, 2);
		write_limit(2);
		send_cmd(KIND_BUILD, 0);
		send_cmd(KIND_QUERY, 2);
		send_cmd(KIND_PRIME, 0);
		send_cmd(KIND_PRIME, 1);
	endtask

	task automatic test_random_phases();
		int lim, r, v;
		for (int ph = 0; ph < 5; ph++) begin
			steady_drive = (ph == 2);
			lim = (ph == 4) ? $urandom_range(4000, 2000) : $urandom_range(700, 3);
			write_limit(lim);
			send_cmd(KIND_BUILD, $urandom_range(65535));
			for (int n = 0; n < 50; n++) begin
				r = $urandom_range(99);
				if (r < 60) v = $urandom_range(covered_limit);
				else if (r < 70) v = $urandom_range(65535);
				else if (r < 88) v = $urandom_range(n_primes + 2);
				else v = $urandom_range(65535);
				if (r < 70) send_cmd(KIND_QUERY, v);
				else if (r < 95) send_cmd(KIND_PRIME, v);
				else if (r < 97) send_cmd(KIND_UNUSED, v);
				else send_cmd(KIND_BUILD, v);
			end
		end
		steady_drive = 1'b0;
	endtask

	task automatic test_full_limit();
		write_limit(SIEVE_MAX);
		send_cmd(KIND_BUILD, 0);
		send_cmd(KIND_QUERY, 65535);
		send_cmd(KIND_QUERY, 65521);
		send_cmd(KIND_QUERY, 32768);
		send_cmd(KIND_QUERY, 60060);   // six distinct primes
		send_cmd(KIND_QUERY, 0);
		send_cmd(KIND_PRIME, 0);
		send_cmd(KIND_PRIME, n_primes - 1);
		send_cmd(KIND_PRIME, n_primes);
		send_cmd(KIND_PRIME, 65535);
		for (int n = 0; n < 40; n++)
			if ($urandom_range(3) == 0) send_cmd(KIND_PRIME, $urandom_range(65535));
			else send_cmd(KIND_QUERY, $urandom_range(65535));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		kind = KIND_BUILD;
		value = '0;
		mismatches = 0;
		steady_drive = 1'b0;
		foreach (spf_table[n]) spf_table[n] = 0;
		n_primes = 0;
		covered_limit = 0;
		limit_reg = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_before_build();
		test_small_limits();
		test_random_phases();
		test_full_limit();
		drain();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** linear_sieve_factorizer_core: PASSED **");
		else
			$display("** linear_sieve_factorizer_core: FAILED **");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("** linear_sieve_factorizer_core: FAILED **");
		$finish;
	end

endmodule

[files.f]
sv/lsf_pkg.sv
sv/lsf_div.sv
sv/linear_sieve_factorizer_core.sv
sv/lsf_chk.sv
tb/sv/tb_linear_sieve_factorizer_core.sv
